// ===== src/jst_pkg.sv =====
// ----------------------------------------------------------------------------
// jst_pkg: shared types and helpers for the JSON stream tokenizer
// Token kinds, error codes, the result record, byte classes and the small
// lookup functions used by the lexer and the result queue.
// ----------------------------------------------------------------------------
package jst_pkg;

  // Default depth of the result queue.
  localparam int RES_DEPTH_DEF = 4;

  // Configuration register indexes.
  localparam logic CFG_MAX_TOKENS = 1'b0;
  localparam logic CFG_MAX_LENGTH = 1'b1;

  // Register reset values.
  localparam logic [5:0]  MAX_TOKENS_RST = 6'd50;
  localparam logic [11:0] MAX_LENGTH_RST = 12'd256;

  // Saturation magnitude of the number accumulator.
  localparam logic [31:0] SAT_MAG   = 32'h8000_0000;
  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

  // Special characters.
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    KIND_LBRACE   = 4'd0,
    KIND_RBRACE   = 4'd1,
    KIND_LBRACKET = 4'd2,
    KIND_RBRACKET = 4'd3,
    KIND_COLON    = 4'd4,
    KIND_COMMA    = 4'd5,
    KIND_STRING   = 4'd6,
    KIND_NUMBER   = 4'd7,
    KIND_NULL     = 4'd8,
    KIND_END      = 4'd9,
    KIND_ERROR    = 4'd10
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNKNOWN  = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_TOO_LONG = 2'd3
  } err_t;

  // What a byte means when no token is open.
  typedef enum logic [2:0] {
    CLS_PUNCT,
    CLS_QUOTE,
    CLS_SPACE,
    CLS_MINUS,
    CLS_NULL_START,
    CLS_DIGIT,
    CLS_BAD
  } byte_class_t;

  // One result item.
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         text;
    logic               done;
    logic signed [31:0] value;
    err_t               err;
    logic [5:0]         token_total;
    logic [5:0]         key_total;
    logic               last;
  } res_t;

  // Results produced by one accepted byte.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } lex_out_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic valid;
    logic room;
  } fifo_stat_t;

  function automatic res_t mk_res(input kind_t kind, input logic [7:0] text,
                                  input logic done, input logic [31:0] value,
                                  input err_t err, input logic [5:0] tc,
                                  input logic [5:0] kc);
    res_t r;
    r.kind        = kind;
    r.text        = text;
    r.done        = done;
    r.value       = value;
    r.err         = err;
    r.token_total = tc;
    r.key_total   = kc;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic byte_class_t byte_class(input logic [7:0] b);
    byte_class_t c;
    case (b)
      8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3A, 8'h2C: c = CLS_PUNCT;
      CH_QUOTE:                                  c = CLS_QUOTE;
      8'h20, 8'h09, 8'h0A, 8'h0D:                c = CLS_SPACE;
      CH_MINUS:                                  c = CLS_MINUS;
      8'h6E:                                     c = CLS_NULL_START;
      default: begin
        if (b >= CH_ZERO && b <= CH_NINE) c = CLS_DIGIT;
        else c = CLS_BAD;
      end
    endcase
    return c;
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] b);
    kind_t k;
    case (b)
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h5B:   k = KIND_LBRACKET;
      8'h5D:   k = KIND_RBRACKET;
      8'h3A:   k = KIND_COLON;
      default: k = KIND_COMMA;
    endcase
    return k;
  endfunction

  // Expected letter of "null" at a given position.
  function automatic logic [7:0] null_letter(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h6E;
      2'd1:    c = 8'h75;
      default: c = 8'h6C;
    endcase
    return c;
  endfunction

endpackage

// ===== src/jst_lexer.sv =====
// ----------------------------------------------------------------------------
// jst_lexer: lexer state and per-byte decode
// Holds the document state and turns one accepted byte into zero, one or
// two result items in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module jst_lexer import jst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  byte_in,
  input  logic [5:0]  max_tokens,
  input  logic [11:0] max_length,
  output lex_out_t    lex_out
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_STR,
    M_NUM,
    M_NULL,
    M_ERR
  } mode_t;

  // Outcome of adding one token against the token limit.
  typedef struct packed {
    logic       ovf;
    logic [5:0] tc;
    logic [5:0] kc;
    res_t       res;
  } tok_t;

  function automatic tok_t add_tok(input kind_t kind, input logic [31:0] value,
                                   input logic [5:0] tc, input logic [5:0] kc,
                                   input logic [5:0] maxt);
    tok_t t;
    t.ovf = (tc >= maxt);
    t.tc  = t.ovf ? tc : tc + 6'd1;
    t.kc  = (!t.ovf && kind == KIND_COLON) ? kc + 6'd1 : kc;
    if (t.ovf) t.res = mk_res(KIND_ERROR, 8'd0, 1'b1, 32'd0, ERR_OVERFLOW, tc, kc);
    else t.res = mk_res(kind, 8'd0, 1'b1, value, ERR_NONE, t.tc, t.kc);
    return t;
  endfunction

  mode_t       mode, mode_next;
  logic [1:0]  null_pos, null_pos_next;
  logic [31:0] accum, accum_next;
  logic        negative, negative_next;
  logic        frozen, frozen_next;
  logic [5:0]  token_cnt, token_cnt_next;
  logic [5:0]  key_cnt, key_cnt_next;
  logic [11:0] byte_cnt, byte_cnt_next;

  logic        is_end;
  logic [31:0] num_val;
  logic [35:0] accum_x10;
  logic [31:0] accum_step;
  logic [3:0]  digit;
  tok_t        str_tok, num_tok, idl_tok, null_tok;

  logic [5:0]  base_tc, base_kc;
  logic        idl_emit;
  res_t        idl_res;
  mode_t       idl_mode;
  logic [5:0]  idl_tc, idl_kc;
  logic [1:0]  idl_np;
  logic [31:0] idl_acc;
  logic        idl_neg, idl_frz;

  res_t        r0, r1;
  logic [1:0]  n_res;

  // Shared decode of the current byte and state.
  assign is_end     = (byte_in == CH_NUL) || (byte_in == CH_STAR);
  assign digit      = byte_in[3:0] - CH_ZERO[3:0];
  assign num_val    = negative ? (32'd0 - accum) : ((accum > POS_LIMIT) ? POS_LIMIT : accum);
  assign accum_x10  = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + {32'd0, digit};
  assign accum_step = (accum_x10 > {4'd0, SAT_MAG}) ? SAT_MAG : accum_x10[31:0];
  assign str_tok    = add_tok(KIND_STRING, 32'd0, token_cnt, key_cnt, max_tokens);
  assign num_tok    = add_tok(KIND_NUMBER, num_val, token_cnt, key_cnt, max_tokens);
  assign null_tok   = add_tok(KIND_NULL, 32'd0, token_cnt, key_cnt, max_tokens);

  // A byte that ends a number is lexed after the number token is counted.
  assign base_tc = (mode == M_NUM) ? num_tok.tc : token_cnt;
  assign base_kc = (mode == M_NUM) ? num_tok.kc : key_cnt;
  assign idl_tok = add_tok(punct_kind(byte_in), 32'd0, base_tc, base_kc, max_tokens);

  // Lexing of a byte while no token is open.
  always_comb begin
    idl_emit = 1'b0;
    idl_res  = '0;
    idl_mode = M_IDLE;
    idl_tc   = base_tc;
    idl_kc   = base_kc;
    idl_np   = null_pos;
    idl_acc  = accum;
    idl_neg  = negative;
    idl_frz  = frozen;
    case (byte_class(byte_in))
      CLS_PUNCT: begin
        idl_emit = 1'b1;
        idl_res  = idl_tok.res;
        idl_tc   = idl_tok.tc;
        idl_kc   = idl_tok.kc;
        idl_mode = idl_tok.ovf ? M_ERR : M_IDLE;
      end
      CLS_QUOTE: idl_mode = M_STR;
      CLS_SPACE: idl_mode = M_IDLE;
      CLS_MINUS: begin
        idl_mode = M_NUM;
        idl_neg  = 1'b1;
        idl_frz  = 1'b0;
        idl_acc  = 32'd0;
      end
      CLS_NULL_START: begin
        idl_mode = M_NULL;
        idl_np   = 2'd1;
      end
      CLS_DIGIT: begin
        idl_mode = M_NUM;
        idl_neg  = 1'b0;
        idl_frz  = 1'b0;
        idl_acc  = {28'd0, digit};
      end
      default: begin
        idl_emit = 1'b1;
        idl_res  = mk_res(KIND_ERROR, 8'd0, 1'b1, 32'd0, ERR_UNKNOWN, base_tc, base_kc);
        idl_mode = M_ERR;
      end
    endcase
  end

  // Next state and results for one byte.
  always_comb begin
    mode_next      = mode;
    null_pos_next  = null_pos;
    accum_next     = accum;
    negative_next  = negative;
    frozen_next    = frozen;
    token_cnt_next = token_cnt;
    key_cnt_next   = key_cnt;
    byte_cnt_next  = byte_cnt;
    r0             = '0;
    r1             = '0;
    n_res          = 2'd0;
    if (is_end) begin
      // Flush any open token, then report the totals.
      n_res = 2'd2;
      case (mode)
        M_STR: begin
          r0 = str_tok.res;
          r1 = mk_res(KIND_END, 8'd0, 1'b1, 32'd0, ERR_NONE, str_tok.tc, str_tok.kc);
        end
        M_NUM: begin
          r0 = num_tok.res;
          r1 = mk_res(KIND_END, 8'd0, 1'b1, 32'd0, ERR_NONE, num_tok.tc, num_tok.kc);
        end
        M_NULL: begin
          r0 = mk_res(KIND_ERROR, 8'd0, 1'b1, 32'd0, ERR_UNKNOWN, token_cnt, key_cnt);
          r1 = mk_res(KIND_END, 8'd0, 1'b1, 32'd0, ERR_NONE, token_cnt, key_cnt);
        end
        default: begin
          n_res = 2'd1;
          r0 = mk_res(KIND_END, 8'd0, 1'b1, 32'd0, ERR_NONE, token_cnt, key_cnt);
        end
      endcase
      mode_next      = M_IDLE;
      null_pos_next  = 2'd0;
      accum_next     = 32'd0;
      negative_next  = 1'b0;
      frozen_next    = 1'b0;
      token_cnt_next = 6'd0;
      key_cnt_next   = 6'd0;
      byte_cnt_next  = 12'd0;
    end else if (mode == M_ERR) begin
      // Bytes are dropped until the end byte.
      n_res = 2'd0;
    end else if (byte_cnt >= max_length) begin
      n_res     = 2'd1;
      r0        = mk_res(KIND_ERROR, 8'd0, 1'b1, 32'd0, ERR_TOO_LONG, token_cnt, key_cnt);
      mode_next = M_ERR;
    end else begin
      byte_cnt_next = byte_cnt + 12'd1;
      case (mode)
        M_STR: begin
          n_res = 2'd1;
          if (byte_in == CH_QUOTE) begin
            r0             = str_tok.res;
            token_cnt_next = str_tok.tc;
            key_cnt_next   = str_tok.kc;
            mode_next      = str_tok.ovf ? M_ERR : M_IDLE;
          end else begin
            r0 = mk_res(KIND_STRING, byte_in, 1'b0, 32'd0, ERR_NONE, token_cnt, key_cnt);
          end
        end
        M_NUM: begin
          if (byte_class(byte_in) == CLS_DIGIT) begin
            if (!frozen) accum_next = accum_step;
          end else if (byte_in == CH_DOT) begin
            frozen_next = 1'b1;
          end else if (num_tok.ovf) begin
            n_res     = 2'd1;
            r0        = num_tok.res;
            mode_next = M_ERR;
          end else begin
            // Number completes, then the byte starts whatever comes next.
            r0             = num_tok.res;
            r1             = idl_res;
            n_res          = idl_emit ? 2'd2 : 2'd1;
            mode_next      = idl_mode;
            token_cnt_next = idl_tc;
            key_cnt_next   = idl_kc;
            null_pos_next  = idl_np;
            accum_next     = idl_acc;
            negative_next  = idl_neg;
            frozen_next    = idl_frz;
          end
        end
        M_NULL: begin
          if (byte_in == null_letter(null_pos)) begin
            if (null_pos == 2'd3) begin
              n_res          = 2'd1;
              r0             = null_tok.res;
              token_cnt_next = null_tok.tc;
              mode_next      = null_tok.ovf ? M_ERR : M_IDLE;
              null_pos_next  = 2'd0;
            end else begin
              null_pos_next = null_pos + 2'd1;
            end
          end else begin
            n_res     = 2'd1;
            r0        = mk_res(KIND_ERROR, 8'd0, 1'b1, 32'd0, ERR_UNKNOWN, token_cnt, key_cnt);
            mode_next = M_ERR;
          end
        end
        default: begin
          r0             = idl_res;
          n_res          = idl_emit ? 2'd1 : 2'd0;
          mode_next      = idl_mode;
          token_cnt_next = idl_tc;
          key_cnt_next   = idl_kc;
          null_pos_next  = idl_np;
          accum_next     = idl_acc;
          negative_next  = idl_neg;
          frozen_next    = idl_frz;
        end
      endcase
    end
  end

  // Mark the final result of the byte.
  always_comb begin
    lex_out.count  = step ? n_res : 2'd0;
    lex_out.first  = r0;
    lex_out.second = r1;
    lex_out.first.last  = (n_res == 2'd1);
    lex_out.second.last = (n_res == 2'd2);
  end

  // Document state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      null_pos  <= 2'd0;
      accum     <= 32'd0;
      negative  <= 1'b0;
      frozen    <= 1'b0;
      token_cnt <= 6'd0;
      key_cnt   <= 6'd0;
      byte_cnt  <= 12'd0;
    end else if (step) begin
      mode      <= mode_next;
      null_pos  <= null_pos_next;
      accum     <= accum_next;
      negative  <= negative_next;
      frozen    <= frozen_next;
      token_cnt <= token_cnt_next;
      key_cnt   <= key_cnt_next;
      byte_cnt  <= byte_cnt_next;
    end
  end

endmodule

// ===== src/jst_res_fifo.sv =====
// ----------------------------------------------------------------------------
// jst_res_fifo: result queue
// Small register queue that takes up to two results per cycle and hands
// out one per beat on the output side.
// ----------------------------------------------------------------------------
module jst_res_fifo import jst_pkg::*; #(
  parameter int Depth = RES_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  lex_out_t   push,
  input  logic       pop,
  output res_t       head,
  output fifo_stat_t stat
);

  localparam int PtrW   = $clog2(Depth);
  localparam int CountW = $clog2(Depth + 1);

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  res_t              entries [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [PtrW-1:0]   wr_ptr1;
  logic [CountW-1:0] count;

  assign wr_ptr1    = inc(wr_ptr);
  assign head       = entries[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.room  = (count <= CountW'(Depth - 2));

  // Result storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr1] <= push.second;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (push.count)
        2'd1:    wr_ptr <= wr_ptr1;
        2'd2:    wr_ptr <= inc(wr_ptr1);
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop) rd_ptr <= inc(rd_ptr);
      count <= count + CountW'(push.count) - CountW'(pop);
    end
  end

endmodule

// ===== src/json_stream_tokenizer.sv =====
// ----------------------------------------------------------------------------
// json_stream_tokenizer: streaming JSON lexer
// Takes one text byte per beat and sends braces, brackets, colon, comma,
// string, number, null, end and error tokens.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock cycle. Each byte gives zero, one or
// two result beats; all of its decoding is done in the cycle it is accepted,
// and its results go into a small result queue. Input is taken while the
// queue has room for two results, so with a ready consumer the rate is one
// byte per cycle, and a byte that gives two results (a number followed by
// punctuation, or a flush at the end of a document) can hold off the next
// byte while the queue drains. A byte of 0 or '*' ends the document and
// returns all document state, but not the two limit registers, to reset.
module json_stream_tokenizer import jst_pkg::*; #(
  parameter int ResDepth = RES_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input bytes.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  // Results.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] text_byte, [39:8] number_value,
                                 // [41:40] error_code, [47:42] token_total,
                                 // [53:48] key_total, [55:54] zero
  output logic [4:0]  m_tuser,   // [3:0] token_kind, [4] token_done
  output logic        m_tlast,   // last_of_run
  // Register writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  logic [5:0]  max_tokens;
  logic [11:0] max_length;
  logic        accept;
  lex_out_t    lex_out;
  res_t        head;
  fifo_stat_t  stat;

  assign cfg_ready = 1'b1;
  assign s_tready  = stat.room;
  assign accept    = s_tvalid && s_tready;

  // Limit registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_tokens <= MAX_TOKENS_RST;
      max_length <= MAX_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_TOKENS: max_tokens <= cfg_data[5:0];
        CFG_MAX_LENGTH: max_length <= cfg_data;
        default:        max_length <= max_length;
      endcase
    end
  end

  jst_lexer u_lexer (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .byte_in    (s_tdata),
    .max_tokens (max_tokens),
    .max_length (max_length),
    .lex_out    (lex_out)
  );

  jst_res_fifo #(
    .Depth (ResDepth)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (lex_out),
    .pop  (m_tvalid && m_tready),
    .head (head),
    .stat (stat)
  );

  // Output beat packing.
  assign m_tvalid = stat.valid;
  assign m_tdata  = {2'b00, head.key_total, head.token_total, head.err, head.value,
                     head.text};
  assign m_tuser  = {head.done, head.kind};
  assign m_tlast  = head.last;

  // A string content beat is never a completed token.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[4]) |-> (m_tuser[3:0] == KIND_STRING))
    else $error("content beat with kind other than string");

  // Error code is set exactly on error tokens.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser[3:0] == KIND_ERROR) == (m_tdata[41:40] != ERR_NONE)))
    else $error("error code and token kind disagree");

  // Keys are a subset of counted tokens.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[53:48] <= m_tdata[47:42]))
    else $error("key total above token total");

  // The end token is always the final result of its byte.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[3:0] == KIND_END) |-> (m_tlast && m_tuser[4]))
    else $error("end token not marked as last");

endmodule

// ===== verif/json_stream_tokenizer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_stream_tokenizer_test: self-checking testbench for the JSON tokenizer
// Feeds text bytes on the input stream and predicts every result beat with a
// lexer of its own. Covers hand-picked token text, a long output stall, and
// register settings that force token overflow and length errors. After that
// it sends random documents. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module json_stream_tokenizer_test;
  import jst_pkg::*;

  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 4;

  // Punctuation bytes.
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;

  typedef enum logic [2:0] {
    LX_IDLE,
    LX_STRING,
    LX_NUMBER,
    LX_NULL,
    LX_ERROR
  } lex_state_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [4:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_MAX_TOKENS;
  logic [11:0] cfg_data = 12'h000;

  json_stream_tokenizer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Lexer state mirrored by the testbench.
  lex_state_t  lx_mode    = LX_IDLE;
  logic [1:0]  nul_pos    = 2'd0;
  logic [31:0] num_mag    = 32'd0;
  logic        num_neg    = 1'b0;
  logic        num_frozen = 1'b0;
  logic [5:0]  tok_cnt    = 6'd0;
  logic [5:0]  key_cnt    = 6'd0;
  logic [11:0] len_cnt    = 12'd0;
  logic [5:0]  lim_tokens = MAX_TOKENS_RST;
  logic [11:0] lim_length = MAX_LENGTH_RST;

  res_t       expected_tokens[$];
  logic [7:0] doc_bytes[$];

  int mismatch_count = 0;
  int results_checked = 0;
  int error_results = 0;
  int bytes_sent = 0;
  int docs_sent = 0;
  int burst_left = 0;
  int hold_request = 0;
  int hold_left = 0;
  int rx_span = 0;
  int rx_style = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void queue_result(input kind_t k, input logic [7:0] t,
                                       input logic d, input logic [31:0] v,
                                       input err_t e);
    res_t r;
    r.kind        = k;
    r.text        = t;
    r.done        = d;
    r.value       = v;
    r.err         = e;
    r.token_total = tok_cnt;
    r.key_total   = key_cnt;
    r.last        = 1'b0;
    expected_tokens.push_back(r);
  endfunction

  function automatic void flag_error(input err_t e);
    lx_mode = LX_ERROR;
    queue_result(KIND_ERROR, 8'h00, 1'b1, 32'd0, e);
  endfunction

  // A completed token either counts or turns into an overflow error.
  function automatic bit count_token(input kind_t k, input logic [31:0] v);
    if (tok_cnt >= lim_tokens) begin
      flag_error(ERR_OVERFLOW);
      return 1'b0;
    end
    tok_cnt = tok_cnt + 6'd1;
    if (k == KIND_COLON) key_cnt = key_cnt + 6'd1;
    queue_result(k, 8'h00, 1'b1, v, ERR_NONE);
    return 1'b1;
  endfunction

  function automatic logic [31:0] number_word();
    if (num_neg) return 32'd0 - num_mag;
    return (num_mag > POS_LIMIT) ? POS_LIMIT : num_mag;
  endfunction

  function automatic logic [7:0] null_char(input logic [1:0] pos);
    case (pos)
      2'd0:    return 8'h6E;
      2'd1:    return 8'h75;
      default: return 8'h6C;
    endcase
  endfunction

  function automatic void clear_document();
    lx_mode    = LX_IDLE;
    nul_pos    = 2'd0;
    num_mag    = 32'd0;
    num_neg    = 1'b0;
    num_frozen = 1'b0;
    tok_cnt    = 6'd0;
    key_cnt    = 6'd0;
    len_cnt    = 12'd0;
  endfunction

  // A byte seen while no token is open.
  function automatic void start_token(input logic [7:0] b);
    case (b)
      CH_LBRACE:   void'(count_token(KIND_LBRACE, 32'd0));
      CH_RBRACE:   void'(count_token(KIND_RBRACE, 32'd0));
      CH_LBRACKET: void'(count_token(KIND_LBRACKET, 32'd0));
      CH_RBRACKET: void'(count_token(KIND_RBRACKET, 32'd0));
      CH_COLON:    void'(count_token(KIND_COLON, 32'd0));
      CH_COMMA:    void'(count_token(KIND_COMMA, 32'd0));
      CH_QUOTE:    lx_mode = LX_STRING;
      8'h20, 8'h09, 8'h0A, 8'h0D: ;
      CH_MINUS: begin
        lx_mode    = LX_NUMBER;
        num_neg    = 1'b1;
        num_frozen = 1'b0;
        num_mag    = 32'd0;
      end
      8'h6E: begin
        lx_mode = LX_NULL;
        nul_pos = 2'd1;
      end
      default: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          lx_mode    = LX_NUMBER;
          num_neg    = 1'b0;
          num_frozen = 1'b0;
          num_mag    = {24'd0, b - CH_ZERO};
        end else begin
          flag_error(ERR_UNKNOWN);
        end
      end
    endcase
  endfunction

  // Works out the result beats of one accepted byte and queues them.
  function automatic void lex_predict(input logic [7:0] b);
    int   base_count;
    res_t r;
    logic [63:0] prod;
    base_count = expected_tokens.size();
    if (b == CH_NUL || b == CH_STAR) begin
      // End of document: flush the open token, report totals, start over.
      if (lx_mode == LX_STRING) void'(count_token(KIND_STRING, 32'd0));
      else if (lx_mode == LX_NUMBER) void'(count_token(KIND_NUMBER, number_word()));
      else if (lx_mode == LX_NULL) flag_error(ERR_UNKNOWN);
      queue_result(KIND_END, 8'h00, 1'b1, 32'd0, ERR_NONE);
      clear_document();
    end else if (lx_mode == LX_ERROR) begin
      // Bytes are dropped until the end byte.
    end else if (len_cnt >= lim_length) begin
      flag_error(ERR_TOO_LONG);
    end else begin
      len_cnt = len_cnt + 12'd1;
      case (lx_mode)
        LX_STRING: begin
          if (b == CH_QUOTE) begin
            lx_mode = LX_IDLE;
            void'(count_token(KIND_STRING, 32'd0));
          end else begin
            queue_result(KIND_STRING, b, 1'b0, 32'd0, ERR_NONE);
          end
        end
        LX_NUMBER: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            if (!num_frozen) begin
              prod = {32'd0, num_mag} * 64'd10 + {56'd0, b - CH_ZERO};
              num_mag = (prod > {32'd0, SAT_MAG}) ? SAT_MAG : prod[31:0];
            end
          end else if (b == CH_DOT) begin
            num_frozen = 1'b1;
          end else begin
            // The terminating byte is lexed again once the number is out.
            lx_mode = LX_IDLE;
            if (count_token(KIND_NUMBER, number_word())) start_token(b);
          end
        end
        LX_NULL: begin
          if (b == null_char(nul_pos)) begin
            if (nul_pos == 2'd3) begin
              lx_mode = LX_IDLE;
              nul_pos = 2'd0;
              void'(count_token(KIND_NULL, 32'd0));
            end else begin
              nul_pos = nul_pos + 2'd1;
            end
          end else begin
            flag_error(ERR_UNKNOWN);
          end
        end
        default: begin
          lx_mode = LX_IDLE;
          start_token(b);
        end
      endcase
    end
    // Mark the final beat of this byte.
    if (expected_tokens.size() > base_count) begin
      r = expected_tokens.pop_back();
      r.last = 1'b1;
      expected_tokens.push_back(r);
    end
  endfunction

  // ------------------------------------------------------------ output side

  // The receiver switches between styles of readiness and honors long holds.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        if (rx_span == 0) begin
          rx_span = $urandom_range(20, 120);
          rx_style = $urandom_range(0, 2);
        end
        rx_span = rx_span - 1;
        case (rx_style)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 1) == 1);
          default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Each result beat is checked against the oldest expected token.
  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_tokens.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none actual kind %0d data %0h",
                 $time, m_tuser[3:0], m_tdata);
      end else begin
        want = expected_tokens.pop_front();
        results_checked++;
        if (want.kind == KIND_ERROR) error_results++;
        compare_field("token_kind", 32'(want.kind), 32'(m_tuser[3:0]));
        compare_field("token_done", 32'(want.done), 32'(m_tuser[4]));
        compare_field("text_byte", 32'(want.text), 32'(m_tdata[7:0]));
        compare_field("number_value", want.value, m_tdata[39:8]);
        compare_field("error_code", 32'(want.err), 32'(m_tdata[41:40]));
        compare_field("token_total", 32'(want.token_total), 32'(m_tdata[47:42]));
        compare_field("key_total", 32'(want.key_total), 32'(m_tdata[53:48]));
        compare_field("tdata padding", 32'd0, 32'(m_tdata[55:54]));
        compare_field("last_of_run", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    forever begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                   $time, QUIET_LIMIT, expected_tokens.size());
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // ------------------------------------------------------------- input side

  // Sends one byte; bursts of random length are separated by random gaps.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    lex_predict(b);
    bytes_sent++;
    if (b == CH_NUL || b == CH_STAR) docs_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stops sending and waits until every expected result has arrived.
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic idx, input logic [11:0] val);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAX_TOKENS) lim_tokens = val[5:0];
    else lim_length = val;
  endtask

  task automatic set_limits(input logic [5:0] tokens, input logic [11:0] length);
    logic [5:0] junk;
    // Upper data bits are don't-care for the token limit.
    junk = 6'($urandom_range(0, 63));
    write_limit(CFG_MAX_TOKENS, {junk, tokens});
    write_limit(CFG_MAX_LENGTH, length);
  endtask

  // Builds a document of mostly well-formed tokens with random content,
  // some noise and broken words, and sends it followed by an end byte.
  task automatic send_random_document(input int tokens);
    int pick;
    int n;
    logic [7:0] ch;
    doc_bytes.delete();
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        case ($urandom_range(0, 5))
          0: doc_bytes.push_back(CH_LBRACE);
          1: doc_bytes.push_back(CH_RBRACE);
          2: doc_bytes.push_back(CH_LBRACKET);
          3: doc_bytes.push_back(CH_RBRACKET);
          4: doc_bytes.push_back(CH_COLON);
          default: doc_bytes.push_back(CH_COMMA);
        endcase
      end else if (pick < 50) begin
        doc_bytes.push_back(CH_QUOTE);
        n = ($urandom_range(0, 39) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          ch = 8'($urandom_range(1, 255));
          if (ch == CH_QUOTE) ch = 8'h80;
          doc_bytes.push_back(ch);
        end
        if ($urandom_range(0, 9) != 0) doc_bytes.push_back(CH_QUOTE);
      end else if (pick < 70) begin
        if ($urandom_range(0, 3) == 0) doc_bytes.push_back(CH_MINUS);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
        if (n == 0 && (doc_bytes.size() == 0 || doc_bytes[$] != CH_MINUS)) n = 1;
        for (int i = 0; i < n; i++)
          doc_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
          doc_bytes.push_back(CH_DOT);
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++)
            doc_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 9) == 0) doc_bytes.push_back(CH_DOT);
        end
      end else if (pick < 80) begin
        // Mostly whole words; sometimes a prefix followed by a stray letter.
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 4;
        for (int i = 0; i < n; i++) doc_bytes.push_back(null_char(i[1:0]));
        if (n < 4) doc_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
      end else if (pick < 90) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: doc_bytes.push_back(8'h20);
            1: doc_bytes.push_back(8'h09);
            2: doc_bytes.push_back(8'h0A);
            default: doc_bytes.push_back(8'h0D);
          endcase
        end
      end else begin
        doc_bytes.push_back(8'($urandom_range(1, 255)));
      end
    end
    doc_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_NUL : CH_STAR);
    foreach (doc_bytes[i]) send_byte(doc_bytes[i]);
  endtask

  // ------------------------------------------------------------------ tests

  // Every token kind, byte extremes, and the end byte in odd places.
  task automatic test_directed_tokens();
    send_text("{\"\377\001\":-9.5,[null]}");
    send_byte(CH_NUL);
    // Whitespace, a lone minus, then an end byte inside a string.
    send_text(" --7\t\"x*");
    // End inside a number, end inside a partial null, unknown character.
    send_text("4*nu*@x*");
    settle_idle();
  endtask

  // The receiver stops for a long stretch while punctuation keeps coming.
  task automatic test_backpressure();
    hold_request = 150;
    send_byte(CH_LBRACKET);
    for (int i = 0; i < 40; i++) send_byte(CH_COMMA);
    send_byte(CH_RBRACKET);
    send_byte(CH_STAR);
    settle_idle();
  endtask

  // Register settings from one extreme to the other.
  task automatic test_register_limits();
    logic [5:0]  tok_lims[6] = '{6'd1, 6'd63, 6'd0, 6'd3, 6'd63, 6'd7};
    logic [11:0] len_lims[6] = '{12'd4095, 12'd1, 12'd0, 12'd40, 12'd4095, 12'd12};
    for (int i = 0; i < 6; i++) begin
      set_limits(tok_lims[i], len_lims[i]);
      for (int d = 0; d < 2; d++) send_random_document($urandom_range(1, 15));
    end
    // A document of more random tokens than the largest token limit.
    set_limits(6'd63, 12'd4095);
    send_random_document(70);
    set_limits(MAX_TOKENS_RST, MAX_LENGTH_RST);
  endtask

  task automatic test_random_documents();
    int start_bytes;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < 250) begin
      if ($urandom_range(0, 9) == 0) send_random_document($urandom_range(52, 70));
      else send_random_document($urandom_range(1, 20));
      if ($urandom_range(0, 7) == 0) settle_idle();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_tokens();
    test_backpressure();
    test_register_limits();
    test_random_documents();
    settle_idle();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes in %0d documents over several limit settings.",
             bytes_sent, docs_sent);
    $display("Checked %0d result beats, %0d of them error tokens; %0d mismatches.",
             results_checked, error_results, mismatch_count);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
